// ===== design/mfd_pkg.sv =====
// Shared types, constants and helpers for the motor feedback decoder.
`timescale 1ns / 1ps

package mfd_pkg;

    // Defaults for the top-level parameters
    localparam int AVG_DEPTH_DEF   = 8;
    localparam int MOTOR_COUNT_DEF = 4;

    // Field widths
    localparam int ID_W       = 11;
    localparam int MASK_W     = 4;
    localparam int OFFSET_W   = 13;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int ADJ_W      = 18;   // offset-corrected, mirrored angle
    localparam int POS_W      = 32;
    localparam int TURN_SHIFT = 13;   // 8192 ticks per turn
    localparam int MIDX_OUT_W = 2;

    // Motors that have their own offset and reverse bit
    localparam int CFG_MOTORS = 4;

    // Configuration port
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REV_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_M0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_M1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_M2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_M3 = 3'd5;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd516;

    localparam int ANGLE_MAX  = 8191;
    localparam int WRAP_LIMIT = 8000;

    // Queue depths
    localparam int MQ_DEPTH = 4;
    localparam int OQ_DEPTH = 8;

    // Classified request handed from front to back (motor index travels beside it)
    typedef struct packed {
        logic                     acc;
        logic                     rev;
        logic signed [ADJ_W-1:0]  angle;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] cur;
    } front_item_t;

    typedef struct packed {
        logic                     frame_accepted;
        logic [MIDX_OUT_W-1:0]    motor_index;
        logic signed [POS_W-1:0]  position_total;
        logic signed [WORD_W-1:0] velocity_avg;
        logic signed [WORD_W-1:0] current_value;
        logic signed [WORD_W-1:0] turn_count;
    } result_t;

    // Negation that saturates the most negative value
    function automatic logic signed [WORD_W-1:0] neg_sat16(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v == {1'b1, {(WORD_W-1){1'b0}}})
            r = {1'b0, {(WORD_W-1){1'b1}}};
        else
            r = -v;
        return r;
    endfunction

endpackage

// ===== design/motor_feedback_decoder_unit.sv =====
// Motor feedback decoder: multi-turn position, averaged speed and current per motor.
// Usage:
//   Requests enter through a queue-style port: frame_id and payload_b0..b5 are
//   taken at a clock edge with push high and full low. Results leave the same
//   way: while empty is low the oldest result sits on the result ports and it
//   is taken at an edge with pop high. Every request gives exactly one result;
//   a frame whose identifier maps to no motor returns frame_accepted low and
//   zeros elsewhere, and leaves all motor state untouched.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register at once;
//   write only while no request is in flight.
//   A request passes through the internal queue and back-end stages 1 to 3 before
//   its result enters the result queue. Throughput: one request per cycle while the
//   result queue has room, set by the per-motor read-modify-write of running sum,
//   turns and last position. Reset: registers return to their defaults, histories
//   read as zero, both queues empty. No clearing pass is needed.
//   Stall: when pop stays low the 8-entry result queue fills, the back end stops
//   draining the 4-entry internal queue, and full rises once that is full.
`timescale 1ns / 1ps

module motor_feedback_decoder_unit import mfd_pkg::*; #(
    parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic [ID_W-1:0]          frame_id,
    input  logic [BYTE_W-1:0]        payload_b0,
    input  logic [BYTE_W-1:0]        payload_b1,
    input  logic [BYTE_W-1:0]        payload_b2,
    input  logic [BYTE_W-1:0]        payload_b3,
    input  logic [BYTE_W-1:0]        payload_b4,
    input  logic [BYTE_W-1:0]        payload_b5,
    output logic                     empty,
    input  logic                     pop,
    output logic                     frame_accepted,
    output logic [MIDX_OUT_W-1:0]    motor_index,
    output logic signed [POS_W-1:0]  position_total,
    output logic signed [WORD_W-1:0] velocity_avg,
    output logic signed [WORD_W-1:0] current_value,
    output logic signed [WORD_W-1:0] turn_count
);

    localparam int MIDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int MQ_W     = $bits(front_item_t) + MIDX_W;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    front_item_t          f_item;
    logic [MIDX_W-1:0]    f_motor;
    front_item_t          q_item;
    logic [MIDX_W-1:0]    q_motor;
    logic                 q_empty;
    logic                 q_pop;
    logic [OQ_CNT_W-1:0]  out_count;
    logic                 res_valid;
    result_t              res;
    result_t              res_head;

    mfd_front #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_id  (frame_id),
        .payload_b0(payload_b0),
        .payload_b1(payload_b1),
        .payload_b2(payload_b2),
        .payload_b3(payload_b3),
        .payload_b4(payload_b4),
        .payload_b5(payload_b5),
        .item      (f_item),
        .motor     (f_motor)
    );

    mfd_fifo #(
        .WIDTH(MQ_W),
        .DEPTH(MQ_DEPTH)
    ) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata({f_item, f_motor}),
        .pop  (q_pop),
        .rdata({q_item, q_motor}),
        .full (full),
        .empty(q_empty),
        .count()
    );

    mfd_back #(
        .MOTOR_COUNT(MOTOR_COUNT),
        .AVG_DEPTH  (AVG_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_motor  (q_motor),
        .q_pop    (q_pop),
        .out_count(out_count),
        .res_valid(res_valid),
        .res      (res)
    );

    mfd_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(OQ_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_valid),
        .wdata(res),
        .pop  (pop),
        .rdata(res_head),
        .full (),
        .empty(empty),
        .count(out_count)
    );

    assign frame_accepted = res_head.frame_accepted;
    assign motor_index    = res_head.motor_index;
    assign position_total = res_head.position_total;
    assign velocity_avg   = res_head.velocity_avg;
    assign current_value  = res_head.current_value;
    assign turn_count     = res_head.turn_count;

endmodule

// ===== design/mfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/mfd_fifo.sv =====
// Small register-based FIFO used for the internal and result queues.
`timescale 1ns / 1ps

module mfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/mfd_front.sv =====
// Front end: configuration registers, identifier decode and angle/current preparation.
`timescale 1ns / 1ps

module mfd_front import mfd_pkg::*; #(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ID_W-1:0]       frame_id,
    input  logic [BYTE_W-1:0]     payload_b0,
    input  logic [BYTE_W-1:0]     payload_b1,
    input  logic [BYTE_W-1:0]     payload_b2,
    input  logic [BYTE_W-1:0]     payload_b3,
    input  logic [BYTE_W-1:0]     payload_b4,
    input  logic [BYTE_W-1:0]     payload_b5,
    output front_item_t           item,
    output logic [MIDX_W-1:0]     motor
);

    logic [ID_W-1:0]     base_id_reg;
    logic [MASK_W-1:0]   rev_mask_reg;
    logic [OFFSET_W-1:0] offset_reg [CFG_MOTORS];

    logic signed [ID_W+1:0]   idx_diff;
    logic [ID_W:0]            idx_mag;
    logic                     in_range;
    logic                     in_cfg;
    logic [1:0]               cfg_sel;
    logic [OFFSET_W-1:0]      off;
    logic                     rev;
    logic signed [WORD_W-1:0] angle_raw;
    logic signed [WORD_W-1:0] cur_raw;
    logic signed [WORD_W:0]   rel;
    logic signed [ADJ_W-1:0]  rel_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg  <= BASE_ID_RESET;
            rev_mask_reg <= '0;
            for (int k = 0; k < CFG_MOTORS; k++)
            begin
                offset_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_ID:   base_id_reg   <= cfg_data[ID_W-1:0];
                REG_REV_MASK:  rev_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_OFFSET_M0: offset_reg[0] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_M1: offset_reg[1] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_M2: offset_reg[2] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_M3: offset_reg[3] <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // index = id - base - 1
    assign idx_diff = $signed({2'b00, frame_id}) - $signed({2'b00, base_id_reg})
                      - $signed((ID_W+2)'(1));
    assign idx_mag  = idx_diff[ID_W:0];
    assign in_range = !idx_diff[ID_W+1] && (idx_mag < (ID_W+1)'(MOTOR_COUNT));
    assign in_cfg   = !idx_diff[ID_W+1] && (idx_mag < (ID_W+1)'(CFG_MOTORS));
    assign cfg_sel  = idx_mag[1:0];
    assign motor    = idx_mag[MIDX_W-1:0];

    assign off = in_cfg ? offset_reg[cfg_sel] : '0;
    assign rev = in_cfg && rev_mask_reg[cfg_sel];

    assign angle_raw = $signed({payload_b0, payload_b1});
    assign cur_raw   = $signed({payload_b4, payload_b5});

    assign rel     = $signed({angle_raw[WORD_W-1], angle_raw})
                     - $signed({{(WORD_W+1-OFFSET_W){1'b0}}, off});
    assign rel_ext = {{(ADJ_W-WORD_W-1){rel[WORD_W]}}, rel};

    always_comb
    begin
        item.acc   = in_range;
        item.rev   = rev;
        item.angle = rev ? ($signed(ADJ_W'(ANGLE_MAX)) - rel_ext) : rel_ext;
        item.speed = $signed({payload_b2, payload_b3});
        item.cur   = rev ? neg_sat16(cur_raw) : cur_raw;
    end

endmodule

// ===== design/mfd_back.sv =====
// Back end: speed history and running mean, turn tracking, result assembly.
`timescale 1ns / 1ps

module mfd_back import mfd_pkg::*; #(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
    localparam int MIDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  front_item_t         q_item,
    input  logic [MIDX_W-1:0]   q_motor,
    output logic                q_pop,
    input  logic [OQ_CNT_W-1:0] out_count,
    output logic                res_valid,
    output result_t             res
);

    localparam int PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int H_DEPTH = MOTOR_COUNT * AVG_DEPTH;
    localparam int HADDR_W = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
    localparam int DIV_L   = $clog2(AVG_DEPTH);
    localparam int SUM_W   = WORD_W + DIV_L;
    localparam int DIV_K   = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int POSX_W  = POS_W + 1;
    // ceil(2^K / depth): exact truncated quotient for any magnitude below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    // per-motor state
    logic [PTR_W-1:0]        hist_ptr_reg [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]  filled_reg;
    logic signed [SUM_W-1:0] sum_reg      [MOTOR_COUNT];
    logic signed [POS_W-1:0] last_pos_reg [MOTOR_COUNT];
    logic signed [WORD_W-1:0] turns_reg   [MOTOR_COUNT];

    // issue
    logic [OQ_CNT_W:0]  used;
    logic               issue;
    logic [PTR_W-1:0]   cur_ptr;
    logic [HADDR_W-1:0] haddr;
    logic [WORD_W-1:0]  hist_rdata;

    // stage 1
    logic                s1_valid_reg;
    front_item_t         s1_item_reg;
    logic [MIDX_W-1:0]   s1_motor_reg;
    logic                s1_filled_reg;

    logic signed [WORD_W-1:0] old_speed;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [WORD_W-1:0] turns_cur;
    logic signed [POSX_W-1:0] pos_raw;
    logic signed [POSX_W-1:0] pos_diff;
    logic signed [POSX_W-1:0] pos_next;
    logic signed [WORD_W-1:0] turns_next;
    logic                     s1_commit;

    // stage 2
    logic                     s2_valid_reg;
    logic                     s2_acc_reg;
    logic                     s2_rev_reg;
    logic [MIDX_W-1:0]        s2_motor_reg;
    logic signed [POS_W-1:0]  s2_pos_reg;
    logic signed [WORD_W-1:0] s2_turns_reg;
    logic signed [SUM_W-1:0]  s2_sum_reg;
    logic signed [WORD_W-1:0] s2_cur_reg;
    logic [SUM_W-1:0]         sum_mag;

    // stage 3
    logic                     s3_valid_reg;
    logic                     s3_acc_reg;
    logic                     s3_rev_reg;
    logic                     s3_neg_reg;
    logic [MIDX_W-1:0]        s3_motor_reg;
    logic signed [POS_W-1:0]  s3_pos_reg;
    logic signed [WORD_W-1:0] s3_turns_reg;
    logic signed [WORD_W-1:0] s3_cur_reg;
    logic [PROD_W-1:0]        s3_prod_reg;
    logic [WORD_W:0]          quot;
    logic [WORD_W:0]          quot_signed;
    logic signed [WORD_W-1:0] vel_mean;

    // Issue only with room guaranteed in the result queue, so stages never stall.
    assign used = (OQ_CNT_W+1)'(out_count) + (OQ_CNT_W+1)'(s1_valid_reg)
                + (OQ_CNT_W+1)'(s2_valid_reg) + (OQ_CNT_W+1)'(s3_valid_reg);
    assign issue = !q_empty && (used < (OQ_CNT_W+1)'(OQ_DEPTH));
    assign q_pop = issue;

    assign cur_ptr = hist_ptr_reg[q_motor];
    assign haddr   = HADDR_W'(q_motor) * HADDR_W'(AVG_DEPTH) + HADDR_W'(cur_ptr);

    // read and write same slot; the RAM returns the old sample
    mfd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(H_DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (issue && q_item.acc),
        .waddr(haddr),
        .wdata(q_item.speed),
        .raddr(haddr),
        .rdata(hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            for (int k = 0; k < MOTOR_COUNT; k++)
            begin
                hist_ptr_reg[k] <= '0;
            end
        end
        else if (issue && q_item.acc)
        begin
            if (cur_ptr == PTR_W'(AVG_DEPTH - 1))
            begin
                hist_ptr_reg[q_motor] <= '0;
                filled_reg[q_motor]   <= 1'b1;
            end
            else
            begin
                hist_ptr_reg[q_motor] <= cur_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg   <= q_item;
        s1_motor_reg  <= q_motor;
        s1_filled_reg <= filled_reg[q_motor];
    end

    // ---- stage 1: running sum and turn tracking ----
    // a slot not yet written since reset reads as zero
    assign old_speed = s1_filled_reg ? $signed(hist_rdata) : '0;
    assign sum_next  = sum_reg[s1_motor_reg]
                     + SUM_W'(s1_item_reg.speed) - SUM_W'(old_speed);
    assign turns_cur = turns_reg[s1_motor_reg];
    assign pos_raw   = POSX_W'(s1_item_reg.angle)
                     + $signed({{(POSX_W-WORD_W-TURN_SHIFT){turns_cur[WORD_W-1]}},
                                turns_cur, {TURN_SHIFT{1'b0}}});
    assign pos_diff  = pos_raw - POSX_W'(last_pos_reg[s1_motor_reg]);
    assign s1_commit = s1_valid_reg && s1_item_reg.acc;

    always_comb
    begin
        pos_next   = pos_raw;
        turns_next = turns_cur;
        if (pos_diff > $signed(POSX_W'(WRAP_LIMIT)))
        begin
            pos_next   = pos_raw - $signed(POSX_W'(1 << TURN_SHIFT));
            turns_next = turns_cur - 1'b1;
        end
        else if (pos_diff < -$signed(POSX_W'(WRAP_LIMIT)))
        begin
            pos_next   = pos_raw + $signed(POSX_W'(1 << TURN_SHIFT));
            turns_next = turns_cur + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MOTOR_COUNT; k++)
            begin
                sum_reg[k]      <= '0;
                last_pos_reg[k] <= '0;
                turns_reg[k]    <= '0;
            end
        end
        else if (s1_commit)
        begin
            sum_reg[s1_motor_reg]      <= sum_next;
            last_pos_reg[s1_motor_reg] <= pos_next[POS_W-1:0];
            turns_reg[s1_motor_reg]    <= turns_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_acc_reg   <= s1_item_reg.acc;
        s2_rev_reg   <= s1_item_reg.rev;
        s2_motor_reg <= s1_motor_reg;
        s2_pos_reg   <= pos_next[POS_W-1:0];
        s2_turns_reg <= turns_next;
        s2_sum_reg   <= sum_next;
        s2_cur_reg   <= s1_item_reg.cur;
    end

    // ---- stage 2: mean magnitude by reciprocal multiply ----
    assign sum_mag = s2_sum_reg[SUM_W-1] ? SUM_W'(-s2_sum_reg) : SUM_W'(s2_sum_reg);

    always_ff @(posedge clk)
    begin
        s3_acc_reg   <= s2_acc_reg;
        s3_rev_reg   <= s2_rev_reg;
        s3_neg_reg   <= s2_sum_reg[SUM_W-1];
        s3_motor_reg <= s2_motor_reg;
        s3_pos_reg   <= s2_pos_reg;
        s3_turns_reg <= s2_turns_reg;
        s3_cur_reg   <= s2_cur_reg;
        s3_prod_reg  <= PROD_W'(sum_mag) * PROD_W'(RECIP);
    end

    // ---- stage 3: sign, reverse, result ----
    assign quot        = s3_prod_reg[DIV_K +: WORD_W+1];
    assign quot_signed = s3_neg_reg ? (WORD_W+1)'(-quot) : quot;
    assign vel_mean    = $signed(quot_signed[WORD_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign res_valid = s3_valid_reg;

    always_comb
    begin
        res = '0;
        if (s3_acc_reg)
        begin
            res.frame_accepted = 1'b1;
            res.motor_index    = MIDX_OUT_W'(s3_motor_reg);
            res.position_total = s3_pos_reg;
            res.velocity_avg   = s3_rev_reg ? neg_sat16(vel_mean) : vel_mean;
            res.current_value  = s3_cur_reg;
            res.turn_count     = s3_turns_reg;
        end
    end

endmodule

// ===== sim/motor_feedback_decoder_unit_tb.sv =====
// Self-checking testbench for motor_feedback_decoder_unit: random bursts, stalls, own decoder model.
`timescale 1ns / 1ps

module motor_feedback_decoder_unit_tb;
    import mfd_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int TICKS_PER_TURN = 1 << TURN_SHIFT;
    localparam int WORD_MAX       = 32767;
    localparam int WIND_LAPS      = 4;   // 8 turns per lap

    typedef struct packed {
        logic                   hold;   // sender waits for all results before this request
        logic [ID_W-1:0]        id;
        logic [5:0][BYTE_W-1:0] by;     // by[0] is payload byte 0
    } fb_frame_t;

    typedef enum logic [1:0] {DRAIN_FREE, DRAIN_SPOTTY, DRAIN_HALF, DRAIN_CHOKED} drain_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  pop       = 1'b0;
    fb_frame_t             drv_frame = '0;

    logic                     full;
    logic                     empty;
    logic [ID_W-1:0]          frame_id;
    logic [BYTE_W-1:0]        payload_b0, payload_b1, payload_b2;
    logic [BYTE_W-1:0]        payload_b3, payload_b4, payload_b5;
    logic                     frame_accepted;
    logic [MIDX_OUT_W-1:0]    motor_index;
    logic signed [POS_W-1:0]  position_total;
    logic signed [WORD_W-1:0] velocity_avg;
    logic signed [WORD_W-1:0] current_value;
    logic signed [WORD_W-1:0] turn_count;

    assign frame_id   = drv_frame.id;
    assign payload_b0 = drv_frame.by[0];
    assign payload_b1 = drv_frame.by[1];
    assign payload_b2 = drv_frame.by[2];
    assign payload_b3 = drv_frame.by[3];
    assign payload_b4 = drv_frame.by[4];
    assign payload_b5 = drv_frame.by[5];

    motor_feedback_decoder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .frame_id       (frame_id),
        .payload_b0     (payload_b0),
        .payload_b1     (payload_b1),
        .payload_b2     (payload_b2),
        .payload_b3     (payload_b3),
        .payload_b4     (payload_b4),
        .payload_b5     (payload_b5),
        .empty          (empty),
        .pop            (pop),
        .frame_accepted (frame_accepted),
        .motor_index    (motor_index),
        .position_total (position_total),
        .velocity_avg   (velocity_avg),
        .current_value  (current_value),
        .turn_count     (turn_count)
    );

    always #5 clk = ~clk;

    // Register shadows
    logic [ID_W-1:0]     base_sh = BASE_ID_RESET;
    logic [MASK_W-1:0]   rev_sh  = '0;
    logic [OFFSET_W-1:0] offset_sh [CFG_MOTORS];

    // Decoder state, all zero after reset
    logic signed [WORD_W-1:0] spd_hist [MOTOR_COUNT_DEF][AVG_DEPTH_DEF];
    int                       hist_wr  [MOTOR_COUNT_DEF];
    int                       spd_sum  [MOTOR_COUNT_DEF];
    int                       last_pos [MOTOR_COUNT_DEF];
    logic signed [WORD_W-1:0] turn_cnt [MOTOR_COUNT_DEF];

    fb_frame_t frame_q[$];
    result_t   expected_res_q[$];

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int gap_left     = 0;
    int burst_left   = 8;
    int gen_ang [4];
    int gen_spd [4];

    initial
    begin
        for (int k = 0; k < CFG_MOTORS; k++)
            offset_sh[k] = '0;
        for (int k = 0; k < MOTOR_COUNT_DEF; k++)
        begin
            for (int i = 0; i < AVG_DEPTH_DEF; i++)
                spd_hist[k][i] = '0;
            hist_wr[k]  = 0;
            spd_sum[k]  = 0;
            last_pos[k] = 0;
            turn_cnt[k] = '0;
        end
        for (int k = 0; k < 4; k++)
        begin
            gen_ang[k] = 0;
            gen_spd[k] = 0;
        end
    end

    function automatic int neg_clip(input int v);
        return (-v > WORD_MAX) ? WORD_MAX : -v;
    endfunction

    // Advances the motor state by one frame and returns the decoded result
    function automatic result_t decode_frame(input fb_frame_t f);
        int                       id_i;
        int                       base_i;
        int                       m;
        int                       ang;
        int                       spd;
        int                       cur;
        int                       vel;
        int                       off;
        longint                   pos;
        longint                   diff;
        logic signed [WORD_W-1:0] w;
        result_t                  r;
        r      = '0;
        id_i   = int'(f.id);
        base_i = int'(base_sh);
        m      = id_i - base_i - 1;
        if (m < 0 || m >= MOTOR_COUNT_DEF)
            return r;
        off = (m < CFG_MOTORS) ? int'(offset_sh[m]) : 0;
        w   = {f.by[0], f.by[1]};
        ang = int'(w);
        w   = {f.by[2], f.by[3]};
        spd = int'(w);
        w   = {f.by[4], f.by[5]};
        cur = int'(w);

        spd_sum[m]             = spd_sum[m] + spd - spd_hist[m][hist_wr[m]];
        spd_hist[m][hist_wr[m]] = spd[WORD_W-1:0];
        hist_wr[m]             = (hist_wr[m] + 1) % AVG_DEPTH_DEF;
        vel                    = spd_sum[m] / AVG_DEPTH_DEF;   // truncates toward zero

        pos = longint'(ang);
        pos = pos - off;
        if (m < CFG_MOTORS && rev_sh[m])
        begin
            pos = ANGLE_MAX - pos;
            vel = neg_clip(vel);
            cur = neg_clip(cur);
        end
        pos  = pos + turn_cnt[m] * TICKS_PER_TURN;
        diff = pos - last_pos[m];
        if (diff > WRAP_LIMIT)
        begin
            turn_cnt[m] = turn_cnt[m] - 16'sd1;
            pos         = pos - TICKS_PER_TURN;
        end
        else if (diff < -WRAP_LIMIT)
        begin
            turn_cnt[m] = turn_cnt[m] + 16'sd1;
            pos         = pos + TICKS_PER_TURN;
        end
        last_pos[m] = int'(pos);

        r.frame_accepted = 1'b1;
        r.motor_index    = m[MIDX_OUT_W-1:0];
        r.position_total = pos[POS_W-1:0];
        r.velocity_avg   = vel[WORD_W-1:0];
        r.current_value  = cur[WORD_W-1:0];
        r.turn_count     = turn_cnt[m];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Request driver: bursts of random length, random gaps in between
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                expected_res_q.push_back(decode_frame(drv_frame));
            if (push && full)
            begin
                // request still waiting to be taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (frame_q.size() != 0 && (!frame_q[0].hold || expected_res_q.size() == 0))
            begin
                drv_frame <= frame_q.pop_front();
                push      <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                push <= 1'b0;
        end
    end

    // Result monitor with its own stall pattern
    drain_mode_t drain_mode  = DRAIN_FREE;
    int          mode_left   = 100;
    int          stall_phase = 0;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_res_q.size() == 0)
                flag_mismatch("result with no request pending");
            else
            begin
                want = expected_res_q.pop_front();
                check_field("frame_accepted", 32'(frame_accepted), 32'(want.frame_accepted));
                check_field("motor_index", 32'(motor_index), 32'(want.motor_index));
                check_field("position_total", position_total, want.position_total);
                check_field("velocity_avg", 32'(velocity_avg), 32'(want.velocity_avg));
                check_field("current_value", 32'(current_value), 32'(want.current_value));
                check_field("turn_count", 32'(turn_count), 32'(want.turn_count));
            end
        end
        if (mode_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        stall_phase++;
        case (drain_mode)
            DRAIN_FREE:   pop <= 1'b1;
            DRAIN_SPOTTY: pop <= ($urandom_range(0, 3) != 0);
            DRAIN_HALF:   pop <= stall_phase[1];
            default:      pop <= (stall_phase % 16) >= 12;   // long stalls back up both queues
        endcase
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("motor_feedback_decoder_unit_tb failed");
            $finish;
        end
    end

    task automatic queue_frame(input int id, input int ang, input int spd,
                               input int cur, input logic hold);
        fb_frame_t f;
        f.hold = hold;
        f.id   = id[ID_W-1:0];
        f.by   = {cur[7:0], cur[15:8], spd[7:0], spd[15:8], ang[7:0], ang[15:8]};
        frame_q.push_back(f);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_BASE_ID:  base_sh = val[ID_W-1:0];
            REG_REV_MASK: rev_sh  = val[MASK_W-1:0];
            default:      offset_sh[idx - REG_OFFSET_M0] = val[OFFSET_W-1:0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input int base, input int mask, input int o0, input int o1,
                              input int o2, input int o3);
        set_reg(REG_BASE_ID, base);
        set_reg(REG_REV_MASK, mask);
        set_reg(REG_OFFSET_M0, o0);
        set_reg(REG_OFFSET_M1, o1);
        set_reg(REG_OFFSET_M2, o2);
        set_reg(REG_OFFSET_M3, o3);
    endtask

    // Sampled on the falling edge so the driver's updates have settled
    task automatic drain_all();
        while (frame_q.size() != 0 || push || expected_res_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly smooth per-motor angle and speed tracks, with noise ids and odd words mixed in
    task automatic queue_random(input int n);
        int k;
        int sel;
        int id;
        int step;
        int base;
        int ang;
        int spd;
        int cur;
        base = int'(base_sh);
        for (int i = 0; i < n; i++)
        begin
            k   = $urandom_range(0, 3);
            sel = $urandom_range(0, 99);
            if (sel < 8)
                id = $urandom_range(0, 2047);
            else if (sel < 14)
            begin
                case ($urandom_range(0, 2))
                    0:       id = base;
                    1:       id = base + 5;
                    default: id = base + 1 + $urandom_range(4, 40);
                endcase
            end
            else
                id = base + 1 + k;

            sel = $urandom_range(0, 99);
            if (sel < 85)
            begin
                step       = $urandom_range(0, 6000);
                step       = step - 3000;
                gen_ang[k] = ((gen_ang[k] + step) % 8192 + 8192) % 8192;
                ang        = gen_ang[k];
            end
            else if (sel < 93)
            begin
                gen_ang[k] = $urandom_range(0, 8191);
                ang        = gen_ang[k];
            end
            else
                ang = $urandom;

            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                step       = $urandom_range(0, 1600);
                gen_spd[k] = gen_spd[k] + step - 800;
                if (gen_spd[k] > WORD_MAX)
                    gen_spd[k] = WORD_MAX;
                if (gen_spd[k] < -WORD_MAX - 1)
                    gen_spd[k] = -WORD_MAX - 1;
                spd = gen_spd[k];
            end
            else if (sel < 80)
            begin
                gen_spd[k] = $urandom_range(0, 1) ? WORD_MAX : -WORD_MAX - 1;
                spd        = gen_spd[k];
            end
            else
                spd = $urandom;

            sel = $urandom_range(0, 99);
            if (sel < 10)
                cur = 'h8000;
            else if (sel < 15)
                cur = 'h7FFF;
            else
                cur = $urandom;

            queue_frame(id, ang, spd, cur, i == 0 || $urandom_range(0, 149) == 0);
        end
    endtask

    initial
    begin
        int base;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: extremes of every word, rejected ids on both sides, wrap both ways
        base = int'(base_sh);
        queue_frame(base + 1, 'h0000, 'h7FFF, 'h8000, 1'b0);
        queue_frame(base,     'hFFFF, 'hFFFF, 'hFFFF, 1'b0);   // one below motor 0
        queue_frame(base + 5, 'h1234, 'h8000, 'h0001, 1'b0);   // past the last motor
        queue_frame(0,        'hA5A5, 'h5A5A, 'hFFFF, 1'b0);
        queue_frame(2047,     'hFFFF, 'hFFFF, 'hFFFF, 1'b0);
        queue_frame(base + 2, 'hFFFF, 'h8000, 'h7FFF, 1'b0);   // sign bit in angle word
        queue_frame(base + 3, ANGLE_MAX, 'h0001, 'h0000, 1'b0);
        queue_frame(base + 3, 0, 'h0002, 'h0000, 1'b0);
        queue_frame(base + 3, WRAP_LIMIT, 'h0003, 'h0000, 1'b0);
        queue_frame(base + 4, 'h8000, 'hFFF9, 'h0000, 1'b0);   // mean -7/8 truncates to 0
        queue_frame(base + 4, 'h8000, 'hFFFE, 'h0000, 1'b0);
        queue_random(220);
        drain_all();

        // All motors reversed with full offset: mirrored angles and saturating negation
        set_config(0, 'hF, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
        for (int i = 0; i < AVG_DEPTH_DEF; i++)
            queue_frame(1, ANGLE_MAX - i * 100, 'h8000, 'h8000, 1'b0);
        queue_frame(0, 'hFFFF, 'hFFFF, 'hFFFF, 1'b0);
        queue_frame(5, 'h0000, 'h0000, 'h0000, 1'b0);
        queue_frame(2, 'h0000, 'h1111, 'h0001, 1'b0);
        queue_frame(3, 'hFFFF, 'h7FFF, 'h7FFF, 1'b0);
        queue_frame(4, 'h7FFF, 'h0000, 'h0001, 1'b0);
        queue_random(220);
        drain_all();

        set_config(2043, 'b0101, 0, 1, 4096, 8190);
        queue_random(220);
        drain_all();

        // Top base: every id maps below motor 0
        set_config(2047, 'hA, 8191, 0, 0, 8191);
        queue_random(40);
        drain_all();

        set_config($urandom_range(0, 2043), $urandom_range(0, 15), $urandom_range(0, 8191),
                   $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191));
        queue_random(300);
        drain_all();

        // Motor 2 winds backward over a few laps of large signed angle jumps
        set_config(int'(BASE_ID_RESET), 0, 0, 0, 0, 0);
        base = int'(base_sh);
        for (int lap = 0; lap < WIND_LAPS; lap++)
        begin
            for (int s = 0; s <= 8; s++)
                queue_frame(base + 3, -32768 + s * (WRAP_LIMIT + 1), $urandom, $urandom, 1'b0);
            for (int s = 1; s <= 8; s++)
                queue_frame(base + 3, -32768 + 8 * (WRAP_LIMIT + 1) - s * WRAP_LIMIT,
                            $urandom, $urandom, 1'b0);
        end
        drain_all();

        if (mismatch_cnt == 0)
            $display("motor_feedback_decoder_unit_tb passed");
        else
            $display("motor_feedback_decoder_unit_tb failed");
        $finish;
    end

endmodule
